// File: rtl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types, constants and codes of the RTCP receiver report block core.
// ----------------------------------------------------------------------------
package rrb_pkg;

    // Default number of per-source slots in the prior-count tables
    localparam int SOURCE_SLOTS_DEF = 16;

    // Width of the source slot field as it arrives on the input channel
    localparam int SLOT_W = 4;

    // Configuration register indexes (byte address 4 * index)
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_LOCAL_ID   = 1'b0;
    localparam logic [0:0] REG_MAX_BLOCKS = 1'b1;
    localparam logic [4:0] MAX_BLOCKS_RST = 5'd31;

    // Result kinds
    localparam logic KIND_BLOCK  = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    // Cumulative loss saturation bounds (signed 24 bits)
    localparam logic signed [23:0] LOST_MAX = 24'sh7fffff;
    localparam logic signed [23:0] LOST_MIN = 24'sh800000;

    // Packet length: six words per report block plus one header word
    localparam logic [7:0] WORDS_PER_BLOCK = 8'd6;
    localparam logic [7:0] HEADER_WORDS    = 8'd1;

    // Divider step counts: full 40-bit dividend, or only the fraction bits
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] DIV_FULL_STEPS = 6'd40;
    localparam logic [CNT_W-1:0] DIV_FRAC_STEPS = 6'd8;

    // Input item
    typedef struct packed {
        logic [SLOT_W-1:0] source_slot;
        logic [31:0]       source_id;
        logic [31:0]       seq_cycles;
        logic [15:0]       highest_seq;
        logic [15:0]       first_seq;
        logic [31:0]       packets_received;
        logic [31:0]       jitter_estimate;
        logic [31:0]       sr_ntp_seconds;
        logic [31:0]       sr_ntp_fraction;
        logic [31:0]       sr_elapsed;
        logic              sr_seen;
        logic              last_source;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic              kind;
        logic [31:0]       block_source_id;
        logic [7:0]        fraction_lost;
        logic signed [23:0] cumulative_lost;
        logic [31:0]       extended_highest;
        logic [31:0]       jitter_out;
        logic [31:0]       last_sr_stamp;
        logic [31:0]       delay_since_sr;
        logic [4:0]        block_count;
        logic [7:0]        length_words;
        logic              last_result;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic diff;
        logic commit;
        logic calc;
        logic div_init;
        logic div_step;
        logic load_block;
        logic load_header;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic emit;
        logic last;
        logic div_done;
        logic out_free;
    } t_sts;

    // Controller states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_READ   = 7'b0000010,
        ST_CALC   = 7'b0000100,
        ST_DINIT  = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_BLOCK  = 7'b0100000,
        ST_HEADER = 7'b1000000
    } t_state;

endpackage

// File: rtl/rrb_stream_if.sv
// ----------------------------------------------------------------------------
// rrb_stream_if
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
interface rrb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rrb_ram.sv
// ----------------------------------------------------------------------------
// rrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/rrb_ctrl.sv
// ----------------------------------------------------------------------------
// rrb_ctrl
// Sequencer: takes one source request at a time and steps the datapath
// through table read, loss arithmetic, fraction division and result loads.
// ----------------------------------------------------------------------------
module rrb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rrb_pkg::t_sts i_sts,
    output rrb_pkg::t_cmd o_cmd
);

    rrb_pkg::t_state r_state;
    rrb_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rrb_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = rrb_pkg::ST_READ;
                end
            end
            rrb_pkg::ST_READ: begin
                o_cmd.diff = 1'b1;
                if (i_sts.emit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = rrb_pkg::ST_CALC;
                end else if (i_sts.last) begin
                    n_state = rrb_pkg::ST_HEADER;
                end else begin
                    n_state = rrb_pkg::ST_IDLE;
                end
            end
            rrb_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = rrb_pkg::ST_DINIT;
            end
            rrb_pkg::ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = rrb_pkg::ST_DIV;
            end
            rrb_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = rrb_pkg::ST_BLOCK;
                end
            end
            rrb_pkg::ST_BLOCK: begin
                if (i_sts.out_free) begin
                    o_cmd.load_block = 1'b1;
                    n_state = i_sts.last ? rrb_pkg::ST_HEADER : rrb_pkg::ST_IDLE;
                end
            end
            rrb_pkg::ST_HEADER: begin
                if (i_sts.out_free) begin
                    o_cmd.load_header = 1'b1;
                    n_state           = rrb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/rrb_dp.sv
// ----------------------------------------------------------------------------
// rrb_dp
// Datapath: request capture, prior-count tables, loss arithmetic, bit-serial
// fraction divider, packet block counter and the result output register.
// ----------------------------------------------------------------------------
module rrb_dp #(
    parameter int SOURCE_SLOTS = rrb_pkg::SOURCE_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrb_pkg::t_cmd      i_cmd,
    output rrb_pkg::t_sts      o_sts,
    input  rrb_pkg::t_in_item  i_item,
    input  logic [31:0]        i_local_id,
    input  logic [4:0]         i_max_blocks,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output rrb_pkg::t_out_item o_out_item
);

    localparam int IDX_W      = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int SLOT_CODES = 2 ** rrb_pkg::SLOT_W;

    // Slot code to table index (code modulo slot count), built at elaboration
    logic [IDX_W-1:0] w_slot_map [SLOT_CODES];
    logic [IDX_W-1:0] w_in_slot;

    for (genvar v = 0; v < SLOT_CODES; v++) begin : g_slot_map
        assign w_slot_map[v] = IDX_W'(v % SOURCE_SLOTS);
    end

    assign w_in_slot = w_slot_map[i_item.source_slot];

    // Captured request
    logic [IDX_W-1:0] r_slot;
    logic [31:0]      r_ssrc;
    logic [31:0]      r_ext_high;
    logic [31:0]      r_expected;
    logic [31:0]      r_recv;
    logic [31:0]      r_jit;
    logic [31:0]      r_stamp;
    logic [31:0]      r_delay;
    logic             r_last;
    logic             r_prior_vld;

    // Per-slot written flags; an unwritten slot reads as zero counts
    logic [SOURCE_SLOTS-1:0] r_slot_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot      <= w_in_slot;
            r_ssrc      <= i_item.source_id;
            r_ext_high  <= i_item.seq_cycles + {16'd0, i_item.highest_seq};
            r_expected  <= i_item.seq_cycles + {16'd0, i_item.highest_seq}
                           - {16'd0, i_item.first_seq} + 32'd1;
            r_recv      <= i_item.packets_received;
            r_jit       <= i_item.jitter_estimate;
            r_stamp     <= {i_item.sr_ntp_seconds[15:0], i_item.sr_ntp_fraction[31:16]};
            r_delay     <= i_item.sr_seen ? i_item.sr_elapsed : 32'd0;
            r_last      <= i_item.last_source;
            r_prior_vld <= r_slot_vld[w_in_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (i_cmd.commit) begin
            r_slot_vld[r_slot] <= 1'b1;
        end
    end

    // Prior expected/received table: {expected, received}
    logic [63:0] w_ram_q;
    logic [31:0] w_prior_exp;
    logic [31:0] w_prior_rec;

    rrb_ram #(
        .WIDTH (64),
        .DEPTH (SOURCE_SLOTS)
    ) u_prior_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit),
        .i_wr_addr (r_slot),
        .i_wr_data ({r_expected, r_recv}),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (w_in_slot),
        .o_rd_data (w_ram_q)
    );

    assign w_prior_exp = r_prior_vld ? w_ram_q[63:32] : 32'd0;
    assign w_prior_rec = r_prior_vld ? w_ram_q[31:0]  : 32'd0;

    // Packet block counter
    logic [4:0] r_blocks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks <= '0;
        end else if (i_cmd.load_header) begin
            r_blocks <= '0;
        end else if (i_cmd.load_block) begin
            r_blocks <= r_blocks + 5'd1;
        end
    end

    // Interval differences and raw cumulative loss
    logic [31:0] r_exp_int;
    logic [31:0] r_rec_int;
    logic [31:0] r_cum_raw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_exp_int <= r_expected - w_prior_exp;
            r_rec_int <= r_recv - w_prior_rec;
            r_cum_raw <= r_expected - r_recv;
        end
    end

    // Interval loss, fraction enable, cumulative saturation
    logic [31:0]        w_lost;
    logic [31:0]        r_lost;
    logic               r_frac_en;
    logic signed [23:0] w_cum_sat;
    logic signed [23:0] r_cum_sat;

    assign w_lost = r_exp_int - r_rec_int;

    always_comb begin
        if ((r_cum_raw[31:23] == 9'h000) || (r_cum_raw[31:23] == 9'h1ff)) begin
            w_cum_sat = r_cum_raw[23:0];
        end else if (r_cum_raw[31]) begin
            w_cum_sat = rrb_pkg::LOST_MIN;
        end else begin
            w_cum_sat = rrb_pkg::LOST_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_lost    <= w_lost;
            r_frac_en <= (r_exp_int != 32'd0) && !w_lost[31] && (w_lost != 32'd0);
            r_cum_sat <= w_cum_sat;
        end
    end

    // Restoring divider, one quotient bit per cycle; only the low 8 bits kept.
    // When loss is below the interval, the upper 32 quotient bits are zero and
    // the partial remainder is the loss itself, so only the fraction bits run.
    logic [rrb_pkg::CNT_W-1:0] r_cnt;
    logic [31:0]               r_rem;
    logic [39:0]               r_dvd;
    logic [7:0]                r_quo;
    logic [32:0]               w_trial;
    logic                      w_ge;

    assign w_trial = {r_rem, r_dvd[39]};
    assign w_ge    = w_trial >= {1'b0, r_exp_int};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_init) begin
            if (!r_frac_en) begin
                r_cnt <= '0;
            end else if (r_lost < r_exp_int) begin
                r_cnt <= rrb_pkg::DIV_FRAC_STEPS;
            end else begin
                r_cnt <= rrb_pkg::DIV_FULL_STEPS;
            end
        end else if (i_cmd.div_step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= '0;
            if (r_lost < r_exp_int) begin
                r_rem <= r_lost;
                r_dvd <= '0;
            end else begin
                r_rem <= '0;
                r_dvd <= {r_lost, 8'd0};
            end
        end else if (i_cmd.div_step && (r_cnt != '0)) begin
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_exp_int}) : w_trial[31:0];
            r_dvd <= {r_dvd[38:0], 1'b0};
            r_quo <= {r_quo[6:0], w_ge};
        end
    end

    // Output register
    logic               r_out_valid;
    rrb_pkg::t_out_item r_out;
    rrb_pkg::t_out_item w_block;
    rrb_pkg::t_out_item w_header;

    always_comb begin
        w_block                  = '0;
        w_block.kind             = rrb_pkg::KIND_BLOCK;
        w_block.block_source_id  = r_ssrc;
        w_block.fraction_lost    = r_quo;
        w_block.cumulative_lost  = r_cum_sat;
        w_block.extended_highest = r_ext_high;
        w_block.jitter_out       = r_jit;
        w_block.last_sr_stamp    = r_stamp;
        w_block.delay_since_sr   = r_delay;
        w_block.last_result      = !r_last;

        w_header                 = '0;
        w_header.kind            = rrb_pkg::KIND_HEADER;
        w_header.block_source_id = i_local_id;
        w_header.block_count     = r_blocks;
        w_header.length_words    = 8'({3'd0, r_blocks} * rrb_pkg::WORDS_PER_BLOCK)
                                   + rrb_pkg::HEADER_WORDS;
        w_header.last_result     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_block || i_cmd.load_header) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_block) begin
            r_out <= w_block;
        end else if (i_cmd.load_header) begin
            r_out <= w_header;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Status
    assign o_sts.emit     = (r_recv != w_prior_rec) && (r_blocks < i_max_blocks);
    assign o_sts.last     = r_last;
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

`ifndef SYNTHESIS
    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(i_cmd.load_block || i_cmd.load_header))
        else $error("result register overwritten while stalled");

    // Partial remainder stays below the divisor while the divider runs
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_rem < r_exp_int))
        else $error("divider remainder out of range");

    // A result appears only after a load command
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.load_block || i_cmd.load_header))
        else $error("result valid without a load");
`endif

endmodule

// File: rtl/rtcp_receiver_report_block_core.sv
// Sequence: an accepted source that emits a block steps through READ, CALC, DINIT and
// DIV, then BLOCK loads it once the output is free. No fraction is computed when the
// loss is not positive or the interval is empty; a loss below the expected interval
// runs only the fraction bits, any other loss the full dividend (one divider bit per
// cycle). A closing header follows the last source's block, or its READ if no block.
// One source at a time, the next taken back in IDLE. Reset: synchronous, active low.
// ----------------------------------------------------------------------------
// rtcp_receiver_report_block_core
// RTCP receiver report block builder: configuration registers on an APB-style
// port, sequencer and datapath for per-source report blocks and packet header.
// ----------------------------------------------------------------------------
module rtcp_receiver_report_block_core #(
    parameter int SOURCE_SLOTS = rrb_pkg::SOURCE_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    rrb_stream_if.sink                  i_in,
    rrb_stream_if.source                o_out
);

    // Configuration registers
    logic [31:0] r_local_id;
    logic [4:0]  r_max_blocks;
    logic [0:0]  w_reg_idx;
    logic        w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_id   <= '0;
            r_max_blocks <= rrb_pkg::MAX_BLOCKS_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                rrb_pkg::REG_LOCAL_ID:   r_local_id   <= pwdata;
                rrb_pkg::REG_MAX_BLOCKS: r_max_blocks <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            rrb_pkg::REG_LOCAL_ID:   prdata = r_local_id;
            rrb_pkg::REG_MAX_BLOCKS: prdata = {27'd0, r_max_blocks};
            default:                 prdata = '0;
        endcase
    end

    // Sequencer and datapath
    rrb_pkg::t_cmd      w_cmd;
    rrb_pkg::t_sts      w_sts;
    rrb_pkg::t_out_item w_out_item;
    logic               w_in_ready;
    logic               w_out_valid;

    rrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rrb_dp #(
        .SOURCE_SLOTS (SOURCE_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_item       (i_in.data),
        .i_local_id   (r_local_id),
        .i_max_blocks (r_max_blocks),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (w_out_valid),
        .o_out_item   (w_out_item)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_item;

endmodule
